// File: rtl/mfap_pkg.sv
// Shared types and constants for the augmenting-path max flow block.
package mfap_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CAP_W     = 30;
    localparam int RES_W     = 32;

    localparam logic [CAP_W-1:0] CAP_INF   = CAP_W'(32'h3f3f3f3f);
    localparam logic [RES_W-1:0] TOTAL_MAX = '1;

    localparam logic [CNT_W-1:0] NODES_MIN = CNT_W'(2);
    localparam logic [CNT_W-1:0] NODES_MAX = CNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_RUN   = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ALU_MIN,
        ALU_SUB,
        ALU_ADD,
        ALU_ACC
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COPY,
        ST_COPY_END,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_RD,
        ST_BFS_CHK,
        ST_PM_RD,
        ST_PM_CHK,
        ST_PU_RD,
        ST_PU_WF,
        ST_PU_WB,
        ST_TOTAL,
        ST_DONE
    } t_state;

endpackage

// File: rtl/mfap_alu.sv
// Shared arithmetic unit: minimum, subtract, add and saturating accumulate.
module mfap_alu
    import mfap_pkg::*;
(
    input  t_alu_op          i_op,
    input  logic [RES_W-1:0] i_a,
    input  logic [RES_W-1:0] i_b,
    output logic [RES_W-1:0] o_res,
    output logic             o_flag
);

    logic [RES_W:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_flag = 1'b0;
        case (i_op)
            ALU_MIN: begin
                o_res = (i_a < i_b) ? i_a : i_b;
            end
            ALU_SUB: begin
                o_res = i_a - i_b;
            end
            ALU_ADD: begin
                o_res = sum[RES_W-1:0];
            end
            ALU_ACC: begin
                // saturate when the total reaches the top value
                o_flag = (sum >= {1'b0, TOTAL_MAX});
                o_res  = o_flag ? TOTAL_MAX : sum[RES_W-1:0];
            end
            default: begin
                o_res = i_a;
            end
        endcase
    end

endmodule

// File: rtl/max_flow_augmenting_path.sv
// Top level: max flow by breadth-first augmenting paths over a dense matrix.
// Flow: write, unused and bad-endpoint run items answer at once; a clear item zeroes the capacity
//   memory; a run item copies the matrix, then per search pops nodes and scans entries (reading
//   unvisited ones only), per path finds the bottleneck and updates the edges, and then finishes.
// Throughput: one item at a time; ready only in idle with the output register free.
// Reset: synchronous active-low; then a pass over the whole capacity memory zeroes it with ready low.
module max_flow_augmenting_path
    import mfap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,     // node_count
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // row[5:0], col[11:6], capacity[41:12], source_node[47:42], sink_node[53:48],
    // zero fill[55:54]
    input  logic [55:0] i_s_tdata,
    // func[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // total flow[31:0], saturated[32], zero fill[39:33]
    output logic [39:0] o_m_tdata,
    // flow_valid[0]
    output logic        o_m_tuser
);

    // ---- input fields ----
    t_func             in_func;
    logic [NODE_W-1:0] in_row, in_col, in_src, in_dst;
    logic [CAP_W-1:0]  in_cap, cap_sat;

    assign in_func = t_func'(i_s_tuser);
    assign in_row  = i_s_tdata[5:0];
    assign in_col  = i_s_tdata[11:6];
    assign in_cap  = i_s_tdata[41:12];
    assign in_src  = i_s_tdata[47:42];
    assign in_dst  = i_s_tdata[53:48];
    assign cap_sat = (in_cap > CAP_INF) ? CAP_INF : in_cap;

    // ---- configuration ----
    logic [CNT_W-1:0] r_node_count, n_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODES_MAX;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // clamp to the supported node range
    assign n_eff = (r_node_count < NODES_MIN) ? NODES_MIN :
                   (r_node_count > NODES_MAX) ? NODES_MAX : r_node_count;

    // ---- state ----
    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_emit, n_emit;
    logic              r_cp_vld;
    logic [ADDR_W-1:0] r_cp_addr;
    logic [NODE_W-1:0] r_src, n_src, r_dst, n_dst, r_u, n_u, r_v, n_v;
    logic [CNT_W-1:0]  r_n, n_n, r_head, n_head, r_tail, n_tail;
    logic [RES_W-1:0]  r_bneck, n_bneck, r_total, n_total;
    logic              r_sat, n_sat;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [NODE_W-1:0] r_parent [MAX_NODES];
    logic [NODE_W-1:0] r_queue  [MAX_NODES];

    // output register
    logic              r_out_valid, n_out_valid;
    logic [RES_W-1:0]  r_out_flow, n_out_flow;
    logic              r_out_fv, n_out_fv, r_out_sat, n_out_sat;

    // ---- memories ----
    logic [CAP_W-1:0]  cap_mem [1 << ADDR_W];
    logic [RES_W-1:0]  res_mem [1 << ADDR_W];
    logic              cap_we;
    logic [ADDR_W-1:0] cap_waddr, cap_raddr;
    logic [CAP_W-1:0]  cap_wdata, r_cap_rdata;
    logic              res_we;
    logic [ADDR_W-1:0] res_waddr, res_raddr;
    logic [RES_W-1:0]  res_wdata, r_res_rdata;

    logic              par_we, q_we;
    logic [NODE_W-1:0] par_addr, par_wdata, par_raddr, q_waddr, q_wdata, q_raddr;
    logic [NODE_W-1:0] r_par_rdata, r_q_rdata;

    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            cap_mem[cap_waddr] <= cap_wdata;
        end
        r_cap_rdata <= cap_mem[cap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        r_res_rdata <= res_mem[res_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_parent[par_addr] <= par_wdata;
        end
        if (q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
        // forward a write in the same cycle so the next state sees it
        r_par_rdata <= (par_we && par_addr == par_raddr) ? par_wdata : r_parent[par_raddr];
        r_q_rdata   <= (q_we && q_waddr == q_raddr) ? q_wdata : r_queue[q_raddr];
    end

    // ---- shared arithmetic unit ----
    t_alu_op          alu_op;
    logic [RES_W-1:0] alu_a, alu_res;
    logic             alu_flag;

    assign alu_a = (alu_op == ALU_ACC) ? r_total : r_res_rdata;

    mfap_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (r_bneck),
        .o_res  (alu_res),
        .o_flag (alu_flag)
    );

    // ---- handshake ----
    logic accept;
    logic run_ok;
    logic last_v;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign run_ok     = accept && in_func == FN_RUN &&
                        {1'b0, in_src} < n_eff && {1'b0, in_dst} < n_eff &&
                        in_src != in_dst;
    assign last_v     = ({1'b0, r_v} == (r_n - CNT_W'(1)));

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && in_func == FN_CLEAR) begin
                    n_state = ST_CLEAR;
                end else if (run_ok) begin
                    n_state = ST_COPY;
                end
            end
            ST_CLEAR: begin
                if (r_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COPY: begin
                if (r_addr == '1) begin
                    n_state = ST_COPY_END;
                end
            end
            ST_COPY_END: n_state = ST_BFS_INIT;
            ST_BFS_INIT: n_state = ST_BFS_POP;
            ST_BFS_POP: begin
                // queue empty means the sink is out of reach
                n_state = (r_head < r_tail) ? ST_BFS_RD : ST_DONE;
            end
            ST_BFS_RD: begin
                if (!r_visited[r_v]) begin
                    n_state = ST_BFS_CHK;
                end else if (last_v) begin
                    n_state = ST_BFS_POP;
                end
            end
            ST_BFS_CHK: begin
                if (r_res_rdata != '0 && r_v == r_dst) begin
                    n_state = ST_PM_RD;
                end else if (last_v) begin
                    n_state = ST_BFS_POP;
                end else begin
                    n_state = ST_BFS_RD;
                end
            end
            ST_PM_RD:    n_state = (r_v == r_src) ? ST_PU_RD : ST_PM_CHK;
            ST_PM_CHK:   n_state = ST_PM_RD;
            ST_PU_RD:    n_state = (r_v == r_src) ? ST_TOTAL : ST_PU_WF;
            ST_PU_WF:    n_state = ST_PU_WB;
            ST_PU_WB:    n_state = ST_PU_RD;
            ST_TOTAL:    n_state = alu_flag ? ST_DONE : ST_BFS_INIT;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---- datapath controls ----
    always_comb begin
        n_addr      = r_addr;
        n_emit      = r_emit;
        n_src       = r_src;
        n_dst       = r_dst;
        n_n         = r_n;
        n_u         = r_u;
        n_v         = r_v;
        n_head      = r_head;
        n_tail      = r_tail;
        n_bneck     = r_bneck;
        n_total     = r_total;
        n_sat       = r_sat;
        n_visited   = r_visited;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_flow  = r_out_flow;
        n_out_fv    = r_out_fv;
        n_out_sat   = r_out_sat;
        cap_we      = 1'b0;
        cap_waddr   = r_addr;
        cap_wdata   = '0;
        cap_raddr   = r_addr;
        res_we      = r_cp_vld;
        res_waddr   = r_cp_addr;
        res_wdata   = {{(RES_W-CAP_W){1'b0}}, r_cap_rdata};
        res_raddr   = {r_u, r_v};
        par_we      = 1'b0;
        par_addr    = r_v;
        par_wdata   = r_u;
        par_raddr   = r_v;
        q_we        = 1'b0;
        q_waddr     = r_tail[NODE_W-1:0];
        q_wdata     = r_v;
        q_raddr     = r_head[NODE_W-1:0];
        alu_op      = ALU_MIN;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // every item but a valid run or a clear answers at once
                    n_out_valid = 1'b1;
                    n_out_flow  = '0;
                    n_out_fv    = 1'b0;
                    n_out_sat   = 1'b0;
                    case (in_func)
                        FN_WRITE: begin
                            cap_we    = 1'b1;
                            cap_waddr = {in_row, in_col};
                            cap_wdata = cap_sat;
                        end
                        FN_RUN: begin
                            n_out_fv = 1'b1;
                            if (run_ok) begin
                                n_out_valid = r_out_valid && !i_m_tready;
                                n_src   = in_src;
                                n_dst   = in_dst;
                                n_n     = n_eff;
                                n_total = '0;
                                n_sat   = 1'b0;
                                n_addr  = '0;
                            end
                        end
                        FN_CLEAR: begin
                            n_out_valid = r_out_valid && !i_m_tready;
                            n_addr      = '0;
                            n_emit      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                cap_we = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == '1 && r_emit) begin
                    n_out_valid = 1'b1;
                    n_out_flow  = '0;
                    n_out_fv    = 1'b0;
                    n_out_sat   = 1'b0;
                end
            end
            ST_COPY: begin
                n_addr = r_addr + ADDR_W'(1);
            end
            ST_BFS_INIT: begin
                n_visited        = '0;
                n_visited[r_src] = 1'b1;
                par_we           = 1'b1;
                par_addr         = r_src;
                par_wdata        = r_src;
                q_we             = 1'b1;
                q_waddr          = '0;
                q_wdata          = r_src;
                q_raddr          = '0;
                n_head           = '0;
                n_tail           = CNT_W'(1);
            end
            ST_BFS_POP: begin
                n_u    = r_q_rdata;
                n_v    = '0;
                n_head = r_head + CNT_W'(1);
            end
            ST_BFS_RD: begin
                // skip visited nodes without a memory read
                if (r_visited[r_v] && !last_v) begin
                    n_v = r_v + NODE_W'(1);
                end
            end
            ST_BFS_CHK: begin
                if (r_res_rdata != '0) begin
                    n_visited[r_v] = 1'b1;
                    par_we         = 1'b1;
                    if (r_tail < NODES_MAX) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + CNT_W'(1);
                    end
                end
                if (r_res_rdata != '0 && r_v == r_dst) begin
                    n_v     = r_dst;
                    n_bneck = {{(RES_W-CAP_W){1'b0}}, CAP_INF};
                end else if (!last_v) begin
                    n_v = r_v + NODE_W'(1);
                end
            end
            ST_PM_RD: begin
                res_raddr = {r_par_rdata, r_v};
                if (r_v == r_src) begin
                    n_v       = r_dst;
                    par_raddr = r_dst;
                end
            end
            ST_PM_CHK: begin
                alu_op    = ALU_MIN;
                n_bneck   = alu_res;
                n_v       = r_par_rdata;
                par_raddr = r_par_rdata;
            end
            ST_PU_RD: begin
                n_u       = r_par_rdata;
                res_raddr = {r_par_rdata, r_v};
            end
            ST_PU_WF: begin
                // subtract on the forward edge, fetch the backward edge
                alu_op    = ALU_SUB;
                res_we    = 1'b1;
                res_waddr = {r_u, r_v};
                res_wdata = alu_res;
                res_raddr = {r_v, r_u};
            end
            ST_PU_WB: begin
                alu_op    = ALU_ADD;
                res_we    = 1'b1;
                res_waddr = {r_v, r_u};
                res_wdata = alu_res;
                n_v       = r_u;
                par_raddr = r_u;
            end
            ST_TOTAL: begin
                alu_op  = ALU_ACC;
                n_total = alu_res;
                n_sat   = alu_flag;
            end
            ST_DONE: begin
                n_out_valid = 1'b1;
                n_out_flow  = r_total;
                n_out_fv    = 1'b1;
                n_out_sat   = r_sat;
            end
            default: begin
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_emit      <= 1'b0;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_visited   <= '0;
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_emit      <= n_emit;
            r_cp_vld    <= (r_state == ST_COPY);
            r_out_valid <= n_out_valid;
            r_visited   <= n_visited;
            r_total     <= n_total;
            r_sat       <= n_sat;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr  <= r_addr;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_n        <= n_n;
        r_u        <= n_u;
        r_v        <= n_v;
        r_bneck    <= n_bneck;
        r_out_flow <= n_out_flow;
        r_out_fv   <= n_out_fv;
        r_out_sat  <= n_out_sat;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_sat, r_out_flow};
    assign o_m_tuser  = r_out_fv;

    // ---- assertions ----
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[32]) |-> (o_m_tdata[31:0] == TOTAL_MAX))
        else $error("saturated result without full total");

    a_nonrun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("non-run result carries data");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BFS_RD || r_state == ST_BFS_CHK) |-> (r_head <= r_tail))
        else $error("search queue head passed tail");

    a_src_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BFS_CHK) |-> r_visited[r_src])
        else $error("source not marked during search");

endmodule

// File: tb/tb_max_flow_augmenting_path.sv
// Testbench for the augmenting-path max flow block: directed table, then random phases.
module tb_max_flow_augmenting_path
    import mfap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 1_000_000;  // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD    = 300;        // receiver hold-off, in cycles

    typedef struct packed {
        logic [31:0] flow;
        logic        valid;
        logic        sat;
    } t_flow_result;

    // One row of the directed table. A row may first write node_count.
    typedef struct {
        bit           cfg_en;
        logic [6:0]   cfg_val;
        t_func        fn;
        int           row;
        int           col;
        logic [29:0]  cap;
        int           src;
        int           snk;
        bit           typed;      // expectation typed in, else taken from the predictor
        t_flow_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [55:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;

    max_flow_augmenting_path i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // Predictor state: a private copy of the capacity matrix and node_count.
    logic [29:0] cap_mem   [0:4095];
    logic [31:0] resid     [0:4095];
    int          came_from [0:63];
    bit          reached   [0:63];
    int          bfs_q     [0:63];
    logic [6:0]  node_cnt;

    t_flow_result flow_expect_q[$];
    t_stim_row    stim_table[$];

    int mismatches;
    int idle_cycles;
    bit no_gaps;       // set for stretches where neither side idles
    bit hold_req;      // ask the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int nodes_in_use();
        if (node_cnt < NODES_MIN) return int'(NODES_MIN);
        if (node_cnt > NODES_MAX) return int'(NODES_MAX);
        return int'(node_cnt);
    endfunction

    // Edmonds-Karp on the private copy; neighbors scanned in increasing index.
    function automatic t_flow_result solve_flow(input int src, input int dst);
        t_flow_result res;
        int           n, i, head, tail, u, v;
        bit           found;
        logic [31:0]  bneck, w;
        res = '{flow: '0, valid: 1'b1, sat: 1'b0};
        n = nodes_in_use();
        if (src >= n || dst >= n || src == dst) return res;
        for (i = 0; i < 4096; i++) resid[i] = {2'b00, cap_mem[i]};
        forever begin
            for (i = 0; i < 64; i++) reached[i] = 1'b0;
            head = 0;
            tail = 0;
            bfs_q[tail++] = src;
            reached[src] = 1'b1;
            came_from[src] = src;
            found = 1'b0;
            while (head < tail && !found) begin
                u = bfs_q[head++];
                for (v = 0; v < n && !found; v++) begin
                    if (!reached[v] && resid[u*64+v] != 0) begin
                        reached[v] = 1'b1;
                        came_from[v] = u;
                        if (tail < 64) bfs_q[tail++] = v;
                        if (v == dst) found = 1'b1;
                    end
                end
            end
            if (!reached[dst]) return res;
            bneck = 32'h3f3f3f3f;
            for (v = dst; v != src; v = came_from[v]) begin
                w = resid[came_from[v]*64+v];
                if (w < bneck) bneck = w;
            end
            for (v = dst; v != src; v = came_from[v]) begin
                u = came_from[v];
                resid[u*64+v] = resid[u*64+v] - bneck;
                resid[v*64+u] = resid[v*64+u] + bneck;
            end
            if ({1'b0, res.flow} + {1'b0, bneck} >= {1'b0, TOTAL_MAX}) begin
                res.flow = TOTAL_MAX;
                res.sat  = 1'b1;
                return res;
            end
            res.flow = res.flow + bneck;
        end
    endfunction

    function automatic t_flow_result predict_item(input t_func fn, input int row, input int col,
                                                  input logic [29:0] cap, input int src,
                                                  input int snk);
        t_flow_result res;
        int           i;
        res = '0;
        case (fn)
            FN_WRITE: begin
                cap_mem[row*64+col] = (cap > CAP_INF) ? CAP_INF : cap;
            end
            FN_RUN: begin
                res = solve_flow(src, snk);
            end
            FN_CLEAR: begin
                for (i = 0; i < 4096; i++) cap_mem[i] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one item, hold it until taken, then record what it should produce.
    task automatic send_item(input t_func fn, input int row, input int col,
                             input logic [29:0] cap, input int src, input int snk,
                             input bit typed, input t_flow_result want);
        int           gap;
        t_flow_result pred;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= fn;
        i_s_tdata  <= {2'b00, 6'(snk), 6'(src), cap, 6'(col), 6'(row)};
        do @(posedge i_clk); while (!o_s_tready);
        pred = predict_item(fn, row, col, cap, src, snk);
        flow_expect_q.insert(flow_expect_q.size(), typed ? want : pred);
    endtask

    // Write node_count only with the block drained and quiet.
    task automatic set_node_count(input logic [6:0] value);
        i_s_tvalid <= 1'b0;
        while (flow_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_cnt = value;
    endtask

    task automatic add_row(input bit cfg_en, input logic [6:0] cfg_val, input t_func fn,
                           input int row, input int col, input logic [29:0] cap,
                           input int src, input int snk, input bit typed,
                           input t_flow_result want);
        t_stim_row r;
        r = '{cfg_en, cfg_val, fn, row, col, cap, src, snk, typed, want};
        stim_table.insert(stim_table.size(), r);
    endtask

    function automatic logic [29:0] pick_capacity();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 30'($urandom);
            2:       return 30'($urandom_range(32'h3f3f3f3f, 32'h3fffffff));
            3:       return 30'($urandom_range(1, 3));
            default: return 30'($urandom_range(1, 100));
        endcase
    endfunction

    // One random phase: set a node count, load a graph, run a few flows.
    task automatic random_phase(input int phase, inout int sent);
        logic [6:0] nc;
        int         n, edges, runs, k, src, snk;
        case ($urandom_range(0, 19))
            0:       nc = 7'($urandom_range(0, 1));
            1:       nc = 7'($urandom_range(65, 127));
            2:       nc = 7'd64;
            3:       nc = 7'd2;
            default: nc = 7'($urandom_range(3, 8));
        endcase
        set_node_count(nc);
        n = nodes_in_use();
        no_gaps = ($urandom_range(0, 3) == 0);
        // one long receiver stall while the sender keeps offering
        if (phase == 2) hold_req = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
            send_item(FN_CLEAR, 0, 0, '0, 0, 0, 1'b0, '0);
            sent++;
        end
        edges = (n == 64) ? 15 : $urandom_range(3, 18);
        for (k = 0; k < edges; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(FN_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                          30'($urandom), $urandom_range(0, 63), $urandom_range(0, 63),
                          1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                send_item(FN_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                          pick_capacity(), $urandom_range(0, 63), $urandom_range(0, 63),
                          1'b0, '0);
            else
                send_item(FN_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          pick_capacity(), $urandom_range(0, 63), $urandom_range(0, 63),
                          1'b0, '0);
            sent++;
        end
        runs = $urandom_range(1, 3);
        for (k = 0; k < runs; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                src = $urandom_range(0, 63);
                snk = $urandom_range(0, 63);
            end else begin
                src = $urandom_range(0, n - 1);
                snk = (src + $urandom_range(1, n - 1)) % n;
            end
            send_item(FN_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      30'($urandom), src, snk, 1'b0, '0);
            sent++;
        end
    endtask

    // Receiver: random hold-offs after each taken result, plus one long stall.
    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                i_m_tready <= 1'b1;
            end else if (i_m_tready && o_m_tvalid) begin
                gap = no_gaps ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_m_tready <= 1'b1;
                end
            end else if (!i_m_tready) begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Check each taken result against the oldest expectation; watch for a hang.
    always @(posedge i_clk) begin
        t_flow_result want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (flow_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata[31:0], '0);
                end else begin
                    want = flow_expect_q.pop_front();
                    if (o_m_tdata[31:0] !== want.flow)
                        report_mismatch("flow", o_m_tdata[31:0], want.flow);
                    if (o_m_tuser !== want.valid)
                        report_mismatch("flow_valid", 32'(o_m_tuser), 32'(want.valid));
                    if (o_m_tdata[32] !== want.sat)
                        report_mismatch("saturated", 32'(o_m_tdata[32]), 32'(want.sat));
                    if (o_m_tdata[39:33] !== '0)
                        report_mismatch("zero fill", 32'(o_m_tdata[39:33]), '0);
                end
            end
        end
    end

    initial begin
        t_flow_result none, run0, sat_run;
        t_stim_row    r;
        int           k, sent, phase;
        none    = '0;
        run0    = '{flow: '0, valid: 1'b1, sat: 1'b0};
        sat_run = '{flow: TOTAL_MAX, valid: 1'b1, sat: 1'b1};
        mismatches  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        node_cnt    = 7'd64;
        for (k = 0; k < 4096; k++) cap_mem[k] = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;

        // Directed table: empty graph, unused code, capacity clamp, corner nodes,
        // equal and out-of-range endpoints, node_count clamps, clear, total overflow.
        add_row(0, 0, FN_RUN,   0, 0, '0, 0, 1, 1, run0);
        add_row(0, 0, FN_NONE,  63, 63, '1, 63, 63, 1, none);
        add_row(0, 0, FN_WRITE, 0, 1, 30'h3fffffff, 0, 0, 1, none);
        add_row(0, 0, FN_WRITE, 1, 63, 30'd5, 0, 0, 1, none);
        add_row(0, 0, FN_WRITE, 63, 63, '0, 0, 0, 1, none);
        add_row(0, 0, FN_RUN,   0, 0, '0, 0, 63, 1, '{32'd5, 1'b1, 1'b0});
        add_row(0, 0, FN_RUN,   0, 0, '0, 63, 63, 1, run0);
        add_row(1, 7'd0, FN_RUN, 0, 0, '0, 0, 1, 1, '{32'h3f3f3f3f, 1'b1, 1'b0});
        add_row(0, 0, FN_RUN,   0, 0, '0, 0, 63, 1, run0);
        add_row(1, 7'd127, FN_RUN, 0, 0, '0, 0, 63, 1, '{32'd5, 1'b1, 1'b0});
        add_row(0, 0, FN_CLEAR, 0, 0, '0, 0, 0, 1, none);
        add_row(0, 0, FN_RUN,   0, 0, '0, 0, 1, 1, run0);
        for (k = 2; k <= 6; k++) begin
            add_row(0, 0, FN_WRITE, 0, k, 30'h3f3f3f3f, 0, 0, 1, none);
            add_row(0, 0, FN_WRITE, k, 1, 30'h3f3f3f3f, 0, 0, 1, none);
        end
        add_row(0, 0, FN_RUN,   0, 0, '0, 0, 1, 1, sat_run);
        add_row(0, 0, FN_WRITE, 1, 0, 30'h3f3f3f40, 0, 0, 1, none);
        add_row(0, 0, FN_RUN,   0, 0, '0, 1, 0, 0, none);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            r = stim_table[k];
            if (r.cfg_en) set_node_count(r.cfg_val);
            send_item(r.fn, r.row, r.col, r.cap, r.src, r.snk, r.typed, r.want);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            random_phase(phase, sent);
            phase++;
        end
        i_s_tvalid <= 1'b0;

        while (flow_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
